/* sv/okld_pkg.sv */
// Package for the ordered key list deque.
// Types, codes and sizes shared by the cell chain and the top level. No dependencies.
package okld_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned OCC_W    = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    KIND_INSERT    = 3'd0,
    KIND_DEL_KEY   = 3'd1,
    KIND_DEL_FIRST = 3'd2,
    KIND_DEL_LAST  = 3'd3,
    KIND_DUMP      = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    STAT_DONE  = 3'd0,
    STAT_NONE  = 3'd1,
    STAT_FULL  = 3'd2,
    STAT_ENTRY = 3'd3,
    STAT_EMPTY = 3'd4
  } status_e;

  typedef struct packed {
    kind_e            kind;
    logic [KEY_W-1:0] key_in;
  } okld_in_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_out;
    status_e          status;
    logic             last;
  } okld_out_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del_key;
    logic del_first;
    logic del_last;
    logic rotate;
  } okld_cmd_t;

endpackage

/* sv/ordered_key_list_deque_top.sv */
// Top level of the ordered key list deque: control, occupancy count and the cell chain.
// Depends on okld_pkg and okld_cell.
//
// Insert, delete-by-key, delete-first and delete-last update the cell chain directly;
// a new item may follow every cycle while busy is low, and its status appears on res_o,
// with res_valid_o high, in the cycle after it is accepted. A dump rotates the cell
// chain one entry per cycle and emits one item per cycle, so it holds busy high until
// every entry is emitted; a dump of an empty list gives one status item in the next
// cycle and never raises busy. Results cannot be stalled: sample them whenever
// res_valid_o is high. Kinds 5 to 7 are ignored.
module ordered_key_list_deque_top import okld_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  okld_in_t  item_i,
  output logic      res_valid_o,
  output okld_out_t res_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_e;

  state_e           state_q, state_d;
  logic [OCC_W-1:0] count_q, count_d;
  logic [OCC_W-1:0] dump_cnt_q, dump_cnt_d;
  logic             res_valid_q, res_valid_d;
  okld_out_t        res_q, res_d;
  okld_cmd_t        cmd;
  logic             acc;
  logic             full, empty;

  logic [KEY_W-1:0]  cell_key [CAPACITY];
  logic [CAPACITY-1:0] cell_vld;
  logic [CAPACITY:0]   hit;

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0] lkey, rkey;
    logic             lvld, rvld;
    if (i == 0) begin : g_front
      assign lkey = item_i.key_in;
      assign lvld = 1'b1;
    end else begin : g_mid_l
      assign lkey = cell_key[i-1];
      assign lvld = cell_vld[i-1];
    end
    if (i == CAPACITY - 1) begin : g_back
      assign rkey = '0;
      assign rvld = 1'b0;
    end else begin : g_mid_r
      assign rkey = cell_key[i+1];
      assign rvld = cell_vld[i+1];
    end
    okld_cell u_cell (
      .clk_i,
      .rst_ni,
      .cmd_i        (cmd),
      .key_i        (item_i.key_in),
      .head_key_i   (cell_key[0]),
      .left_key_i   (lkey),
      .left_valid_i (lvld),
      .right_key_i  (rkey),
      .right_valid_i(rvld),
      .hit_i        (hit[i]),
      .hit_o        (hit[i+1]),
      .key_o        (cell_key[i]),
      .valid_o      (cell_vld[i])
    );
  end

  assign busy  = (state_q == S_DUMP);
  assign acc   = start && !busy;
  assign full  = (count_q == OCC_W'(CAPACITY));
  assign empty = (count_q == '0);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    dump_cnt_d  = dump_cnt_q;
    cmd         = '0;
    res_valid_d = 1'b0;
    res_d       = res_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          res_d.key_out = '0;
          res_d.last    = 1'b1;
          res_d.status  = STAT_DONE;
          res_valid_d   = 1'b1;
          case (item_i.kind)
            KIND_INSERT: begin
              if (full) begin
                res_d.status = STAT_FULL;
              end else begin
                cmd.ins = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            KIND_DEL_KEY: begin
              cmd.del_key = 1'b1;
              if (hit[CAPACITY]) begin
                count_d = count_q - 1'b1;
              end else begin
                res_d.status = STAT_NONE;
              end
            end
            KIND_DEL_FIRST: begin
              if (empty) begin
                res_d.status = STAT_NONE;
              end else begin
                cmd.del_first = 1'b1;
                count_d       = count_q - 1'b1;
              end
            end
            KIND_DEL_LAST: begin
              if (empty) begin
                res_d.status = STAT_NONE;
              end else begin
                cmd.del_last = 1'b1;
                count_d      = count_q - 1'b1;
              end
            end
            KIND_DUMP: begin
              if (empty) begin
                res_d.status = STAT_EMPTY;
              end else begin
                res_valid_d = 1'b0;
                dump_cnt_d  = count_q;
                state_d     = S_DUMP;
              end
            end
            default: begin
              res_valid_d = 1'b0;
            end
          endcase
        end
      end
      S_DUMP: begin
        cmd.rotate    = 1'b1;
        res_valid_d   = 1'b1;
        res_d.key_out = cell_key[0];
        res_d.status  = STAT_ENTRY;
        res_d.last    = (dump_cnt_q == OCC_W'(1));
        dump_cnt_d    = dump_cnt_q - 1'b1;
        if (dump_cnt_q == OCC_W'(1)) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      dump_cnt_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dump_cnt_q  <= dump_cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // valid bits always track the occupancy count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_vld) == int'(count_q))
    else $error("cell valid bits disagree with occupancy");

  // every dump cycle emits one item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DUMP |=> res_valid_o && res_o.status == STAT_ENTRY)
    else $error("dump cycle without result");

  // final dump entry returns control to idle, flagged as last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP && dump_cnt_q == OCC_W'(1)) |=> state_q == S_IDLE && res_o.last)
    else $error("dump did not end on last entry");

  // mutating items give exactly one final status result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (item_i.kind == KIND_INSERT || item_i.kind == KIND_DEL_KEY ||
             item_i.kind == KIND_DEL_FIRST || item_i.kind == KIND_DEL_LAST))
    |=> res_valid_o && res_o.last && state_q == S_IDLE)
    else $error("missing status result");

endmodule

/* sv/okld_cell.sv */
// One cell of the list chain: holds one key and its valid bit.
// Depends on okld_pkg.
module okld_cell import okld_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  okld_cmd_t        cmd_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic [KEY_W-1:0] head_key_i,
  input  logic [KEY_W-1:0] left_key_i,
  input  logic             left_valid_i,
  input  logic [KEY_W-1:0] right_key_i,
  input  logic             right_valid_i,
  input  logic             hit_i,
  output logic             hit_o,
  output logic [KEY_W-1:0] key_o,
  output logic             valid_o
);

  logic [KEY_W-1:0] key_q, key_d;
  logic             valid_q, valid_d;
  logic             match;

  assign match = valid_q & (key_q == key_i);
  assign hit_o = hit_i | match;

  always_comb begin
    key_d   = key_q;
    valid_d = valid_q;
    if (cmd_i.ins) begin
      key_d   = left_key_i;
      valid_d = left_valid_i;
    end else if (cmd_i.del_first || (cmd_i.del_key && hit_o)) begin
      key_d   = right_key_i;
      valid_d = right_valid_i;
    end else if (cmd_i.del_last) begin
      if (!right_valid_i) begin
        valid_d = 1'b0;
      end
    end else if (cmd_i.rotate) begin
      if (right_valid_i) begin
        key_d = right_key_i;
      end else if (valid_q) begin
        key_d = head_key_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o   = key_q;
  assign valid_o = valid_q;

endmodule
